[rtl/best_threshold_split_scorer_assert.svh]
`ifndef BEST_THRESHOLD_SPLIT_SCORER_ASSERT_SVH
`define BEST_THRESHOLD_SPLIT_SCORER_ASSERT_SVH

// clocked check, held off while in reset
`define BTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define BTS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bts_pkg.sv]
package bts_pkg;

  localparam int MAX_SAMPLES_DEF = 256;
  localparam int VALUE_W = 32;
  localparam int LABEL_W = 2;
  localparam int SCORE_W = 9;
  localparam int GAP_W = 32;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 48;

  localparam logic [LABEL_W-1:0] LABEL_NEG = 2'd0;
  localparam logic [LABEL_W-1:0] LABEL_POS = 2'd1;

  // 0.1 in q16.16
  localparam logic signed [VALUE_W:0] NARROW_SPAN = 33'sd6553;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [LABEL_W-1:0]        label;
  } entry_t;

  typedef struct packed {
    logic signed [VALUE_W:0] diff;
    logic                    gt;
  } alu_res_t;

endpackage

[rtl/bts_ram.sv]
module bts_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/bts_alu.sv]
module bts_alu (
  input  logic signed [bts_pkg::VALUE_W-1:0] a,
  input  logic signed [bts_pkg::VALUE_W-1:0] b,
  output bts_pkg::alu_res_t                  res
);

  logic signed [bts_pkg::VALUE_W:0] diff;

  assign diff = {a[bts_pkg::VALUE_W-1], a} - {b[bts_pkg::VALUE_W-1], b};

  always_comb begin
    res.diff = diff;
    res.gt   = !diff[bts_pkg::VALUE_W] && (diff != '0);
  end

endmodule

[rtl/best_threshold_split_scorer.sv]
// Decision stump scorer over one signed q16.16 feature. Samples come in one word at a time
// and are insertion-sorted into a single-port-per-direction RAM; a sample keeps in_tready
// low after it is taken while each earlier sample above it is read and moved up one place,
// since the RAM offers one read and one write per cycle. The word with tlast set starts the
// split scan: a span check on the first and last held samples, then one RAM read, one shared
// subtractor use and one score compare per neighbor pair, plus any wait for a result still
// held in the output register. in_tready is high only while the sequencer is idle; a
// finished result sits in the output register, so the next set can start loading before it
// is taken. A set with a span of at most 0.1, or with no split whose gap is nonzero and at
// least min_gap, gives score 0 and gap 0. Samples beyond MAX_SAMPLES in one set are dropped.
// No clearing pass is needed after reset.
module best_threshold_split_scorer #(
  parameter int MAX_SAMPLES = bts_pkg::MAX_SAMPLES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bts_pkg::IN_DATA_W-1:0]    in_tdata,   // sample_value
  input  logic                             in_tlast,   // last_sample
  input  logic [bts_pkg::LABEL_W-1:0]      in_tuser,   // sample_label
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bts_pkg::OUT_DATA_W-1:0]   out_tdata,  // best_score, best_gap, zero pad
  input  logic                             cfg_wr_en,
  input  logic [bts_pkg::GAP_W-1:0]        cfg_wr_data // min_gap
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int EW = $bits(bts_pkg::entry_t);
  localparam int ScoreW = bts_pkg::SCORE_W;
  localparam int GapW = bts_pkg::GAP_W;
  localparam int PadW = bts_pkg::OUT_DATA_W - ScoreW - GapW;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_INS_RD    = 4'd1;
  localparam logic [3:0] ST_INS_CMP   = 4'd2;
  localparam logic [3:0] ST_SCAN0     = 4'd3;
  localparam logic [3:0] ST_LOAD0     = 4'd4;
  localparam logic [3:0] ST_SPAN      = 4'd5;
  localparam logic [3:0] ST_SCAN_RD   = 4'd6;
  localparam logic [3:0] ST_SCAN_DIFF = 4'd7;
  localparam logic [3:0] ST_SCAN_EVAL = 4'd8;
  localparam logic [3:0] ST_DONE      = 4'd9;

  logic [3:0]            state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         pos_tot_r, pos_tot_nxt;
  logic [CW-1:0]         neg_tot_r, neg_tot_nxt;
  logic [CW-1:0]         pos_r, pos_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         pos_below_r, pos_below_nxt;
  logic [CW-1:0]         neg_below_r, neg_below_nxt;
  logic [CW-1:0]         best_s_r, best_s_nxt;
  logic [GapW-1:0]       best_g_r, best_g_nxt;
  logic [GapW-1:0]       gap_r, gap_nxt;
  logic [GapW-1:0]       min_gap_r, min_gap_nxt;
  bts_pkg::entry_t       new_r, new_nxt;
  bts_pkg::entry_t       prev_r, prev_nxt;
  logic                  last_r, last_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ScoreW-1:0]     out_score_r, out_score_nxt;
  logic [GapW-1:0]       out_gap_r, out_gap_nxt;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  bts_pkg::entry_t       wr_data;
  logic [AW-1:0]         rd_addr;
  logic [EW-1:0]         rd_raw;
  bts_pkg::entry_t       rd_data;
  logic signed [bts_pkg::VALUE_W-1:0] alu_b;
  bts_pkg::alu_res_t     alu_res;

  logic [CW-1:0]         score_a, score_b, score_s;
  logic                  take;
  logic                  in_acc;
  logic                  out_free;

  assign rd_data = bts_pkg::entry_t'(rd_raw);

  bts_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_SAMPLES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign alu_b = (state_r == ST_INS_CMP) ? new_r.value : prev_r.value;

  bts_alu u_alu (
    .a   (rd_data.value),
    .b   (alu_b),
    .res (alu_res)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PadW{1'b0}}, out_gap_r, out_score_r};

  assign score_a = neg_below_r + (pos_tot_r - pos_below_r);
  assign score_b = pos_below_r + (neg_tot_r - neg_below_r);
  assign score_s = (score_a > score_b) ? score_a : score_b;
  assign take    = (gap_r >= min_gap_r) && (gap_r != '0) &&
                   ((score_s > best_s_r) || ((score_s == best_s_r) && (gap_r > best_g_r)));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_tot_nxt   = pos_tot_r;
    neg_tot_nxt   = neg_tot_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    pos_below_nxt = pos_below_r;
    neg_below_nxt = neg_below_r;
    best_s_nxt    = best_s_r;
    best_g_nxt    = best_g_r;
    gap_nxt       = gap_r;
    min_gap_nxt   = cfg_wr_en ? cfg_wr_data : min_gap_r;
    new_nxt       = new_r;
    prev_nxt      = prev_r;
    last_nxt      = last_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_score_nxt = out_score_r;
    out_gap_nxt   = out_gap_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r[AW-1:0];
    wr_data       = new_r;
    rd_addr       = idx_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          new_nxt.value = in_tdata;
          new_nxt.label = in_tuser;
          last_nxt      = in_tlast;
          pos_nxt       = count_r;
          if (count_r < CW'(MAX_SAMPLES)) begin
            state_nxt = ST_INS_RD;
            if (in_tuser == bts_pkg::LABEL_NEG) begin
              neg_tot_nxt = neg_tot_r + 1'b1;
            end else if (in_tuser == bts_pkg::LABEL_POS) begin
              pos_tot_nxt = pos_tot_r + 1'b1;
            end
          end else if (in_tlast) begin
            state_nxt = ST_SCAN0;
          end
        end
      end
      ST_INS_RD: begin
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
          state_nxt = last_r ? ST_SCAN0 : ST_IDLE;
        end else begin
          rd_addr   = AW'(pos_r - 1'b1);
          state_nxt = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        wr_en = 1'b1;
        if (alu_res.gt) begin
          wr_data   = rd_data;
          pos_nxt   = pos_r - 1'b1;
          state_nxt = ST_INS_RD;
        end else begin
          count_nxt = count_r + 1'b1;
          state_nxt = last_r ? ST_SCAN0 : ST_IDLE;
        end
      end
      ST_SCAN0: begin
        best_s_nxt = '0;
        best_g_nxt = '0;
        if (count_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          rd_addr   = '0;
          state_nxt = ST_LOAD0;
        end
      end
      ST_LOAD0: begin
        prev_nxt  = rd_data;
        rd_addr   = AW'(count_r - 1'b1);
        state_nxt = ST_SPAN;
      end
      ST_SPAN: begin
        pos_below_nxt = '0;
        neg_below_nxt = '0;
        idx_nxt       = CW'(1);
        if ($signed(alu_res.diff) <= bts_pkg::NARROW_SPAN) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        rd_addr   = idx_r[AW-1:0];
        state_nxt = ST_SCAN_DIFF;
      end
      ST_SCAN_DIFF: begin
        gap_nxt  = alu_res.diff[GapW-1:0];
        prev_nxt = rd_data;
        if (prev_r.label == bts_pkg::LABEL_NEG) begin
          neg_below_nxt = neg_below_r + 1'b1;
        end else if (prev_r.label == bts_pkg::LABEL_POS) begin
          pos_below_nxt = pos_below_r + 1'b1;
        end
        state_nxt = ST_SCAN_EVAL;
      end
      ST_SCAN_EVAL: begin
        if (take) begin
          best_s_nxt = score_s;
          best_g_nxt = gap_r;
        end
        if (idx_r == count_r - 1'b1) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_score_nxt = ScoreW'(best_s_r);
          out_gap_nxt   = best_g_r;
          count_nxt     = '0;
          pos_tot_nxt   = '0;
          neg_tot_nxt   = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pos_tot_r   <= '0;
      neg_tot_r   <= '0;
      min_gap_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pos_tot_r   <= pos_tot_nxt;
      neg_tot_r   <= neg_tot_nxt;
      min_gap_r   <= min_gap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    idx_r       <= idx_nxt;
    pos_below_r <= pos_below_nxt;
    neg_below_r <= neg_below_nxt;
    best_s_r    <= best_s_nxt;
    best_g_r    <= best_g_nxt;
    gap_r       <= gap_nxt;
    new_r       <= new_nxt;
    prev_r      <= prev_nxt;
    last_r      <= last_nxt;
    out_score_r <= out_score_nxt;
    out_gap_r   <= out_gap_nxt;
  end

endmodule

[rtl/bts_checker.sv]
`include "best_threshold_split_scorer_assert.svh"

module bts_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tlast,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [bts_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int ScoreW = bts_pkg::SCORE_W;
  localparam int GapW = bts_pkg::GAP_W;

  logic [ScoreW-1:0] score;
  logic [GapW-1:0]   gap;

  assign score = out_tdata[ScoreW-1:0];
  assign gap   = out_tdata[ScoreW+GapW-1:ScoreW];

  `BTS_ASSERT_RST(a_reset_idle, !rst_n |=> !out_tvalid, "result word valid after reset")
  `BTS_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata),
    "stalled result word changed")
  `BTS_ASSERT(a_score_gap, out_tvalid && (score != '0) |-> (gap != '0),
    "nonzero score reported with zero gap")
  `BTS_ASSERT(a_pad_zero, out_tvalid |-> (out_tdata[bts_pkg::OUT_DATA_W-1:ScoreW+GapW] == '0),
    "result word padding not zero")
  `BTS_ASSERT(a_last_busy, in_tvalid && in_tready && in_tlast |=> !in_tready,
    "input taken right after a last word")

endmodule

bind best_threshold_split_scorer bts_checker u_bts_checker (.*);
